@@ hdl/sigt_pkg.sv @@
// ----------------------------------------------------------------------------
// sigt_pkg - shared types and constants of the integrality gap tracker
// Field widths, pipeline stage count, the control structs that travel between
// the top level, the lanes and the merge stage, and the saturating adder.
// ----------------------------------------------------------------------------
package sigt_pkg;

    localparam int SIZE_W        = 16;
    localparam int ROW_W         = 4;
    localparam int FRAC_ROW_W    = 64;
    localparam int SUM_W         = 32;
    localparam int CHOSEN_W      = 2;
    localparam int DEF_LANES     = 4;
    localparam int DEF_FRAC_BITS = 16;
    localparam int NUM_STAGES    = 6;
    localparam int GROUP_W       = 4;

    // stage load strobes, one per pipeline stage
    typedef struct packed {
        logic [NUM_STAGES-1:0] ld;
    } t_stage_ld;

    // per-request data that rides beside the lane pipelines
    typedef struct packed {
        logic [SIZE_W-1:0]   size;
        logic [CHOSEN_W-1:0] chosen;
        logic                found;
        logic                last;
    } t_side;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                  input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

endpackage

@@ hdl/sur_integrality_gap_tracker_core.sv @@
// ----------------------------------------------------------------------------
// sur_integrality_gap_tracker_core - sum-up-rounding integrality gap tracker
// Streams schedule cells and reports the running worst gap between the
// integral and relaxed control sums after every cell.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one cell per request:
//   cell size, one-hot integral row, packed fractional row and a last flag.
//   Output channel (o_out_valid / i_out_ready) returns one result request per
//   cell: worst gap so far, chosen control (lowest set row bit) and the
//   sticky error flag raised by a row with no control set.
//   A cell passes the stages in order from acceptance to o_out_valid: product,
//   rounding, accumulation, per-lane gap, group maximum, then the worst-gap/result
//   register. Throughput is one cell per cycle while the receiver takes results,
//   set by the accumulate loop in each lane and the worst-gap compare in the merge.
//   Each stage advances whenever the stage after it is empty or moving, so a
//   stalled receiver first fills pipeline bubbles; o_in_ready drops only once
//   all six stages hold a request.
//   A cell flagged last reports its result, then all sums, the worst gap and
//   the error flag read as zero for the next run.
//   Reset empties the pipeline, marks the lane sums and the worst gap as cleared and clears the error flag.
// ----------------------------------------------------------------------------
module sur_integrality_gap_tracker_core #(
    parameter int LANES     = sigt_pkg::DEF_LANES,
    parameter int FRAC_BITS = sigt_pkg::DEF_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [sigt_pkg::SIZE_W-1:0]       i_cell_size,
    input  logic [sigt_pkg::ROW_W-1:0]        i_control_onehot,
    input  logic [sigt_pkg::FRAC_ROW_W-1:0]   i_frac_row,
    input  logic                              i_last_cell,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [sigt_pkg::SUM_W-1:0]        o_gap_cost,
    output logic [sigt_pkg::CHOSEN_W-1:0]     o_chosen_control,
    output logic                              o_not_integral
);
    import sigt_pkg::*;

    // only the first four lanes can be chosen by the integral row
    localparam int CTRL_LANES = (LANES < ROW_W) ? LANES : ROW_W;

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] rdy;
    t_stage_ld             ld;
    t_side                 in_side;
    t_side                 r_side [NUM_STAGES-1];
    logic [SUM_W-1:0]      gaps   [LANES];
    logic [LANES-1:0]      hit;

    // Stage handshake: advance a stage when its successor can take it.
    always_comb begin
        rdy[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || i_out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
        ld.ld[0] = i_in_valid && rdy[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            ld.ld[k] = r_vld[k-1] && rdy[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_in_ready  = rdy[0];
    assign o_out_valid = r_vld[NUM_STAGES-1];

    // Pick the lowest set control; an empty row leaves found low.
    always_comb begin
        in_side.size   = i_cell_size;
        in_side.last   = i_last_cell;
        in_side.found  = 1'b0;
        in_side.chosen = '0;
        for (int b = CTRL_LANES - 1; b >= 0; b--) begin
            if (i_control_onehot[b]) begin
                in_side.found  = 1'b1;
                in_side.chosen = CHOSEN_W'(b);
            end
        end
    end

    // Carry the per-request side data alongside the lanes.
    always_ff @(posedge i_clk) begin
        if (ld.ld[0]) begin
            r_side[0] <= in_side;
        end
        for (int k = 1; k < NUM_STAGES - 1; k++) begin
            if (ld.ld[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    for (genvar i = 0; i < LANES; i++) begin : g_lane
        logic [FRAC_BITS-1:0] frac;

        // lanes that fall outside the packed row read a zero fraction
        if ((i + 1) * FRAC_BITS <= FRAC_ROW_W) begin : g_frac
            assign frac = i_frac_row[i*FRAC_BITS +: FRAC_BITS];
        end else begin : g_nofrac
            assign frac = '0;
        end

        if (i < ROW_W) begin : g_hit
            assign hit[i] = r_side[1].found && (r_side[1].chosen == CHOSEN_W'(i));
        end else begin : g_nohit
            assign hit[i] = 1'b0;
        end

        sigt_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ld        (ld),
            .i_size      (i_cell_size),
            .i_frac      (frac),
            .i_acc       (r_side[1]),
            .i_hit       (hit[i]),
            .i_gap_found (r_side[2].found),
            .o_gap       (gaps[i])
        );
    end

    sigt_merge #(
        .LANES (LANES)
    ) u_merge (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ld             (ld),
        .i_gaps           (gaps),
        .i_side           (r_side[NUM_STAGES-2]),
        .o_gap_cost       (o_gap_cost),
        .o_chosen_control (o_chosen_control),
        .o_not_integral   (o_not_integral)
    );

endmodule

@@ hdl/sigt_lane.sv @@
// ----------------------------------------------------------------------------
// sigt_lane - one control lane
// Multiply cell size by the lane fraction, round to Q17.1, accumulate the
// relaxed and integral sums and register the absolute gap between them.
// ----------------------------------------------------------------------------
module sigt_lane #(
    parameter int FRAC_BITS = sigt_pkg::DEF_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sigt_pkg::t_stage_ld           i_ld,
    input  logic [sigt_pkg::SIZE_W-1:0]   i_size,
    input  logic [FRAC_BITS-1:0]          i_frac,
    input  sigt_pkg::t_side               i_acc,
    input  logic                          i_hit,
    input  logic                          i_gap_found,
    output logic [sigt_pkg::SUM_W-1:0]    o_gap
);
    import sigt_pkg::*;

    localparam int PROD_W = SIZE_W + FRAC_BITS;
    localparam int Q_W    = SIZE_W + 2;
    localparam logic [PROD_W:0] RND = (PROD_W+1)'(1) << (FRAC_BITS - 2);

    logic [PROD_W-1:0] r_prod;
    logic [Q_W-1:0]    r_q;
    logic [SUM_W-1:0]  r_int;
    logic [SUM_W-1:0]  r_rel;
    logic              r_clr;
    logic [SUM_W-1:0]  r_gap;

    logic [PROD_W:0]   rnd_sum;
    logic [SUM_W-1:0]  base_int;
    logic [SUM_W-1:0]  base_rel;

    assign rnd_sum  = {1'b0, r_prod} + RND;
    assign base_int = r_clr ? '0 : r_int;
    assign base_rel = r_clr ? '0 : r_rel;

    always_ff @(posedge i_clk) begin
        if (i_ld.ld[0]) begin
            r_prod <= PROD_W'(i_size) * PROD_W'(i_frac);
        end
        if (i_ld.ld[1]) begin
            r_q <= rnd_sum[FRAC_BITS-1 +: Q_W];
        end
        if (i_ld.ld[2] && i_acc.found) begin
            r_rel <= sat_add(base_rel, SUM_W'(r_q));
            r_int <= i_hit ? sat_add(base_int, SUM_W'(i_acc.size)) : base_int;
        end
        if (i_ld.ld[3]) begin
            if (!i_gap_found) begin
                r_gap <= '0;
            end else if (r_int >= r_rel) begin
                r_gap <= r_int - r_rel;
            end else begin
                r_gap <= r_rel - r_int;
            end
        end
    end

    // sums read as zero while the clear mark is set; an empty row keeps it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= 1'b1;
        end else if (i_ld.ld[2]) begin
            r_clr <= i_acc.last || (r_clr && !i_acc.found);
        end
    end

    assign o_gap = r_gap;

    a_rel_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ld.ld[2] && i_acc.found && !r_clr) |=> (r_rel >= $past(r_rel)))
        else $error("relaxed sum decreased without a clear");

    a_empty_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ld.ld[2] && !i_acc.found) |=> ($stable(r_int) && $stable(r_rel)))
        else $error("empty row changed a lane sum");

    a_int_other: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ld.ld[2] && i_acc.found && !i_hit && !r_clr) |=> $stable(r_int))
        else $error("integral sum of an unchosen lane changed");

endmodule

@@ hdl/sigt_merge.sv @@
// ----------------------------------------------------------------------------
// sigt_merge - combine lane gaps into the running worst gap
// Take the maximum within groups of lanes, then across groups and the stored
// worst gap; hold the sticky error flag and the result register.
// ----------------------------------------------------------------------------
module sigt_merge #(
    parameter int LANES = sigt_pkg::DEF_LANES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  sigt_pkg::t_stage_ld             i_ld,
    input  logic [sigt_pkg::SUM_W-1:0]      i_gaps [LANES],
    input  sigt_pkg::t_side                 i_side,
    output logic [sigt_pkg::SUM_W-1:0]      o_gap_cost,
    output logic [sigt_pkg::CHOSEN_W-1:0]   o_chosen_control,
    output logic                            o_not_integral
);
    import sigt_pkg::*;

    localparam int GROUPS = (LANES + GROUP_W - 1) / GROUP_W;

    logic [SUM_W-1:0]    grp_max [GROUPS];
    logic [SUM_W-1:0]    r_grp   [GROUPS];
    logic [SUM_W-1:0]    all_max;
    logic [SUM_W-1:0]    worst_eff;
    logic [SUM_W-1:0]    r_worst;
    logic                r_err;
    logic                r_wclr;
    logic [CHOSEN_W-1:0] r_chosen;

    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            grp_max[g] = '0;
            for (int k = 0; k < GROUP_W; k++) begin
                if (g * GROUP_W + k < LANES) begin
                    if (i_gaps[g * GROUP_W + k] > grp_max[g]) begin
                        grp_max[g] = i_gaps[g * GROUP_W + k];
                    end
                end
            end
        end
    end

    assign worst_eff = r_wclr ? '0 : r_worst;

    always_comb begin
        all_max = worst_eff;
        for (int g = 0; g < GROUPS; g++) begin
            if (r_grp[g] > all_max) begin
                all_max = r_grp[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld.ld[4]) begin
            r_grp <= grp_max;
        end
        if (i_ld.ld[5]) begin
            r_worst  <= all_max;
            r_chosen <= i_side.found ? i_side.chosen : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wclr <= 1'b1;
            r_err  <= 1'b0;
        end else if (i_ld.ld[5]) begin
            r_wclr <= i_side.last;
            r_err  <= (r_err && !r_wclr) || !i_side.found;
        end
    end

    assign o_gap_cost       = r_worst;
    assign o_chosen_control = r_chosen;
    assign o_not_integral   = r_err;

    a_worst_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ld.ld[5] && !r_wclr) |=> (r_worst >= $past(r_worst)))
        else $error("worst gap decreased within a run");

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ld.ld[5] && !r_wclr && r_err) |=> r_err)
        else $error("error flag dropped within a run");

    a_empty_worst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ld.ld[5] && !i_side.found && !r_wclr) |=> $stable(r_worst))
        else $error("empty row changed the worst gap");

endmodule

@@ sim/tb_sur_integrality_gap_tracker_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sur_integrality_gap_tracker_core - self-checking bench of the gap tracker
// Streams schedule cells through both valid/ready channels with random gaps
// and receiver stalls, scores every accepted cell in a behavioral model and
// compares each result request field by field against it, or a typed cell
// against its want. Directed table cells come first, then random schedules.
// ----------------------------------------------------------------------------
module tb_sur_integrality_gap_tracker_core;

    import sigt_pkg::*;

    localparam int LANES      = DEF_LANES;
    localparam int FRAC_BITS  = DEF_FRAC_BITS;
    localparam int N_DIRECTED = 18;
    localparam int N_RANDOM   = 1810;
    localparam int STALL_MAX  = 2000;     // cycles without any request moving
    localparam int DRAIN      = 3 * NUM_STAGES;
    localparam int QUIET_LO   = 600;      // random cells sent with no idling
    localparam int QUIET_HI   = 900;
    localparam int MAX_SHOWN  = 20;

    typedef struct packed {
        logic [SUM_W-1:0]    gap;
        logic [CHOSEN_W-1:0] chosen;
        logic                err;
    } t_score;

    // one directed cell; want is used only where typed is set
    typedef struct packed {
        logic [SIZE_W-1:0]     size;
        logic [ROW_W-1:0]      row;
        logic [FRAC_ROW_W-1:0] frac;
        logic                  last;
        logic                  typed;
        t_score                want;
    } t_cell_row;

    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  i_in_valid       = 1'b0;
    logic                  o_in_ready;
    logic [SIZE_W-1:0]     i_cell_size      = '0;
    logic [ROW_W-1:0]      i_control_onehot = '0;
    logic [FRAC_ROW_W-1:0] i_frac_row       = '0;
    logic                  i_last_cell      = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready      = 1'b0;
    logic [SUM_W-1:0]      o_gap_cost;
    logic [CHOSEN_W-1:0]   o_chosen_control;
    logic                  o_not_integral;

    // model state of the tracker
    logic [SUM_W-1:0] lane_int_sum [LANES];
    logic [SUM_W-1:0] lane_rel_sum [LANES];
    logic [SUM_W-1:0] worst_seen;
    logic             empty_seen;

    t_score pending_scores [$];
    t_score head;
    bit     no_idle       = 1'b0;
    int     mismatches    = 0;
    int     results_seen  = 0;
    int     cells_sent    = 0;
    int     schedules     = 0;
    int     empty_rows    = 0;
    int     stall_count   = 0;

    // directed cells: after reset, empty rows, rounding ties, sticky error
    // cleared by the last cell, all-lanes rows
    t_cell_row directed_cells [N_DIRECTED] = '{
        {16'h0000, 4'b0001, 64'h0, 1'b0, 1'b1, 32'h0000_0000, 2'd0, 1'b0},
        {16'hFFFF, 4'b0000, {64{1'b1}}, 1'b1, 1'b1, 32'h0000_0000, 2'd0, 1'b1},
        {16'h1000, 4'b1000, 64'h0, 1'b0, 1'b1, 32'h0000_1000, 2'd3, 1'b0},
        {16'h1000, 4'b1111, 64'h0, 1'b1, 1'b1, 32'h0000_1000, 2'd0, 1'b0},
        {16'hFFFF, 4'b0110, {64{1'b1}}, 1'b0, 1'b0, 35'h0},
        {16'hFFFF, 4'b1100, 64'h0001_FFFF_8000_7FFF, 1'b0, 1'b0, 35'h0},
        {16'h0001, 4'b0100, 64'h8000_8000_8000_8000, 1'b0, 1'b0, 35'h0},
        {16'h0001, 4'b0010, 64'h4000_4000_4000_4000, 1'b0, 1'b0, 35'h0},
        {16'h0001, 4'b0001, 64'h3FFF_3FFF_3FFF_3FFF, 1'b0, 1'b0, 35'h0},
        {16'h0000, 4'b0000, 64'h0, 1'b0, 1'b0, 35'h0},
        {16'h8000, 4'b0001, 64'hAAAA_5555_AAAA_5555, 1'b0, 1'b0, 35'h0},
        {16'h7FFF, 4'b1010, 64'h5555_AAAA_5555_AAAA, 1'b1, 1'b0, 35'h0},
        {16'h1000, 4'b0001, 64'h0000_0000_0000_8000, 1'b1, 1'b1, 32'h0000_0000, 2'd0, 1'b0},
        {16'h1000, 4'b0010, 64'h0000_0000_0000_8000, 1'b1, 1'b1, 32'h0000_1000, 2'd1, 1'b0},
        {16'hFFFF, 4'b0001, 64'hFFFF_0000_FFFF_0000, 1'b0, 1'b0, 35'h0},
        {16'h0F0F, 4'b0101, 64'h0123_4567_89AB_CDEF, 1'b0, 1'b0, 35'h0},
        {16'hF0F0, 4'b1001, 64'hFEDC_BA98_7654_3210, 1'b1, 1'b0, 35'h0},
        {16'h0000, 4'b1111, 64'h0, 1'b1, 1'b1, 32'h0000_0000, 2'd0, 1'b0}
    };

    sur_integrality_gap_tracker_core #(
        .LANES     (LANES),
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_cell_size      (i_cell_size),
        .i_control_onehot (i_control_onehot),
        .i_frac_row       (i_frac_row),
        .i_last_cell      (i_last_cell),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_gap_cost       (o_gap_cost),
        .o_chosen_control (o_chosen_control),
        .o_not_integral   (o_not_integral)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // clamp a running sum at all ones instead of wrapping
    function automatic logic [SUM_W-1:0] clamp_add(input logic [SUM_W-1:0] acc,
                                                   input logic [63:0] inc);
        logic [64:0] total;
        total = {33'h0, acc} + {1'b0, inc};
        return (total > 65'h0_FFFF_FFFF) ? {SUM_W{1'b1}} : total[SUM_W-1:0];
    endfunction

    // score one cell against the model state and advance it
    function automatic t_score score_cell(input logic [SIZE_W-1:0] size,
                                          input logic [ROW_W-1:0] row,
                                          input logic [FRAC_ROW_W-1:0] frac,
                                          input logic last);
        t_score           res;
        logic [63:0]      lane_frac;
        logic [63:0]      prod;
        logic [63:0]      rounded;
        logic [SUM_W-1:0] gap;
        int               pick;
        int               i;
        bit               found;
        pick  = 0;
        found = 1'b0;
        for (i = 0; i < LANES && i < ROW_W; i++) begin
            if (!found && row[i]) begin
                pick  = i;
                found = 1'b1;
            end
        end
        if (!found) begin
            // empty row: raise the sticky flag, leave all sums alone
            empty_seen = 1'b1;
        end else begin
            for (i = 0; i < LANES; i++) begin
                if (i * FRAC_BITS + FRAC_BITS > FRAC_ROW_W)
                    lane_frac = '0;
                else
                    lane_frac = (frac >> (i * FRAC_BITS)) & ((64'd1 << FRAC_BITS) - 1);
                prod    = 64'(size) * lane_frac;
                rounded = (prod + (64'd1 << (FRAC_BITS - 2))) >> (FRAC_BITS - 1);
                lane_rel_sum[i] = clamp_add(lane_rel_sum[i], rounded);
                if (i == pick)
                    lane_int_sum[i] = clamp_add(lane_int_sum[i], 64'(size));
                gap = (lane_int_sum[i] >= lane_rel_sum[i]) ?
                      lane_int_sum[i] - lane_rel_sum[i] : lane_rel_sum[i] - lane_int_sum[i];
                if (gap > worst_seen)
                    worst_seen = gap;
            end
        end
        res.gap    = worst_seen;
        res.chosen = found ? CHOSEN_W'(pick) : '0;
        res.err    = empty_seen;
        if (last) begin
            for (i = 0; i < LANES; i++) begin
                lane_int_sum[i] = '0;
                lane_rel_sum[i] = '0;
            end
            worst_seen = '0;
            empty_seen = 1'b0;
        end
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input logic [SUM_W-1:0] got,
                                 input logic [SUM_W-1:0] want);
        if (mismatches < MAX_SHOWN)
            $display("MISMATCH at result %0d: %s got %0h, expected %0h",
                     results_seen, what, got, want);
        mismatches++;
    endtask

    // present one cell, hold it until accepted, then queue its score
    task automatic send_cell(input logic [SIZE_W-1:0] size,
                             input logic [ROW_W-1:0] row,
                             input logic [FRAC_ROW_W-1:0] frac,
                             input logic last,
                             input logic typed,
                             input t_score want);
        t_score modeled;
        while (!no_idle && $urandom_range(99) < 23) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_cell_size      <= size;
        i_control_onehot <= row;
        i_frac_row       <= frac;
        i_last_cell      <= last;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        modeled = score_cell(size, row, frac, last);
        pending_scores.push_back(typed ? want : modeled);
        cells_sent++;
        if (row == '0)
            empty_rows++;
        if (last)
            schedules++;
    endtask

    // result side: check every accepted result, then pick the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_scores.size() == 0) begin
                flag_mismatch("unexpected result, gap", o_gap_cost, '0);
            end else begin
                head = pending_scores.pop_front();
                if (o_gap_cost !== head.gap)
                    flag_mismatch("gap_cost", o_gap_cost, head.gap);
                if (o_chosen_control !== head.chosen)
                    flag_mismatch("chosen_control", SUM_W'(o_chosen_control),
                                  SUM_W'(head.chosen));
                if (o_not_integral !== head.err)
                    flag_mismatch("not_integral", SUM_W'(o_not_integral),
                                  SUM_W'(head.err));
            end
            results_seen++;
        end
        i_out_ready <= no_idle || ($urandom_range(99) >= 23);
    end

    // watchdog: end the run when neither channel has moved for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n) begin
            stall_count <= 0;
        end else begin
            stall_count <= stall_count + 1;
            if (stall_count >= STALL_MAX) begin
                $display("timeout with %0d results outstanding", pending_scores.size());
                $display("tb_sur_integrality_gap_tracker_core failed");
                $finish;
            end
        end
    end

    initial begin
        logic [SIZE_W-1:0]     size;
        logic [ROW_W-1:0]      row;
        logic [FRAC_ROW_W-1:0] frac;
        logic [FRAC_BITS-1:0]  lane_val;
        int                    run_len;
        int                    k;
        int                    l;
        int                    n_rand;
        for (l = 0; l < LANES; l++) begin
            lane_int_sum[l] = '0;
            lane_rel_sum[l] = '0;
        end
        worst_seen = '0;
        empty_seen = 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < N_DIRECTED; k++)
            send_cell(directed_cells[k].size, directed_cells[k].row,
                      directed_cells[k].frac, directed_cells[k].last,
                      directed_cells[k].typed, directed_cells[k].want);

        // random schedules: mostly valid rows, a few empty ones as noise
        n_rand = 0;
        while (n_rand < N_RANDOM) begin
            run_len = ($urandom_range(7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
            for (k = 0; k < run_len; k++) begin
                case ($urandom_range(9))
                    0:       size = '1;
                    1:       size = '0;
                    2:       size = SIZE_W'($urandom_range(255));
                    default: size = SIZE_W'($urandom);
                endcase
                row = ($urandom_range(99) < 6) ? '0 : ROW_W'($urandom_range(1, 15));
                frac = '0;
                for (l = 0; l < LANES; l++) begin
                    case ($urandom_range(9))
                        0:       lane_val = '0;
                        1:       lane_val = '1;
                        2, 3, 4: lane_val = FRAC_BITS'($urandom);
                        default: lane_val = FRAC_BITS'($urandom_range(1 << (FRAC_BITS - 1)));
                    endcase
                    if (l * FRAC_BITS + FRAC_BITS <= FRAC_ROW_W)
                        frac[l * FRAC_BITS +: FRAC_BITS] = lane_val;
                end
                no_idle = (n_rand >= QUIET_LO) && (n_rand < QUIET_HI);
                send_cell(size, row, frac, k == run_len - 1, 1'b0, '0);
                n_rand++;
            end
        end
        no_idle = 1'b0;

        i_in_valid <= 1'b0;
        while (pending_scores.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        $display("sent %0d cells in %0d schedules (%0d empty rows), checked %0d results",
                 cells_sent, schedules, empty_rows, results_seen);
        $display("random gaps and stalls on both sides plus one unstalled stretch, %0d mismatches",
                 mismatches);
        if (mismatches == 0 && pending_scores.size() == 0) begin
            $display("tb_sur_integrality_gap_tracker_core passed");
        end else begin
            $display("tb_sur_integrality_gap_tracker_core failed");
        end
        $finish;
    end

endmodule
